// ----- hw/rtl/keyed_text_line_decoder_top_macros.svh -----
// assertion macros for the keyed text line decoder
`ifndef KEYED_TEXT_LINE_DECODER_TOP_MACROS_SVH
`define KEYED_TEXT_LINE_DECODER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define KTLD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ktld check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define KTLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ktld check failed: next-cycle implication");

`endif

// ----- hw/rtl/ktld_pkg.sv -----
// shared types and constants of the keyed text line decoder
`timescale 1ns / 1ps

package ktld_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 10;
  localparam int KEY_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int KEY_WORDS  = 8;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [KEY_IDX_W-1:0]  key_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // register indexes of the key tables
  localparam cfg_idx_t CFG_MAIN_KEY_BASE    = 4'd0;
  localparam cfg_idx_t CFG_COMMENT_KEY_BASE = 4'd4;
  localparam cfg_idx_t CFG_NUM_REGS         = 4'd8;

  localparam cfg_data_t MAIN_KEY_RST [4] = '{
    32'h5F99_1B6C, 32'h135F_CDB9, 32'h0E20_04CB, 32'h0EA1_1C5E
  };
  localparam cfg_data_t COMMENT_KEY_RST [4] = '{
    32'h26D6_A867, 32'h1B45_DDB6, 32'h1322_7E32, 32'h3794_C215
  };

  localparam byte_t MARKER     = 8'h40;
  localparam byte_t SLASH      = 8'h2F;
  localparam byte_t TAB        = 8'h09;
  localparam byte_t TAB_CODE   = 8'h9F;
  localparam byte_t SPACE_CODE = 8'h80;
  localparam byte_t SPACE      = 8'h20;
  localparam byte_t CHAR_MASK  = 8'h7F;
  localparam key_idx_t KEY_STEP = 4'd7;

endpackage

// ----- hw/rtl/ktld_in_if.sv -----
// input byte channel of the keyed text line decoder
`timescale 1ns / 1ps

interface ktld_in_if;
  import ktld_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  line_start;
  len_t  line_length;
  logic  line_end;

  modport source (output valid, output data_byte, output line_start,
                  output line_length, output line_end, input ready);
  modport sink (input valid, input data_byte, input line_start,
                input line_length, input line_end, output ready);
endinterface

// ----- hw/rtl/ktld_out_if.sv -----
// result byte channel of the keyed text line decoder
`timescale 1ns / 1ps

interface ktld_out_if;
  import ktld_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

// ----- hw/rtl/keyed_text_line_decoder_top.sv -----
// Keyed text line decoder. Each input byte is deciphered by a single pass of logic
// (key table select, xor, tab and space fixups) straight into the output register, so
// one byte is accepted per cycle as long as the output is taken. Out valid rises in the
// cycle after a byte is accepted, unless it is a marker. A line starting with '@' is
// encrypted; the marker byte produces no output, the rest are decoded with the main key
// until two decoded slashes switch to the comment key. Other lines pass through. The user
// must write the key tables through the cfg port while no bytes are in flight; the block does not enforce it.
`timescale 1ns / 1ps
`include "keyed_text_line_decoder_top_macros.svh"

module keyed_text_line_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  ktld_in_if.sink              in_if,
  ktld_out_if.source           out_if,
  input  logic                 cfg_we,
  input  ktld_pkg::cfg_idx_t   cfg_index,
  input  ktld_pkg::cfg_data_t  cfg_wdata
);
  import ktld_pkg::*;

  cfg_data_t key_words_r [KEY_WORDS];

  logic     enc_r, enc_nxt;
  logic     comment_r, comment_nxt;
  key_idx_t key_idx_r, key_idx_nxt;
  logic     prev_r, prev_nxt;
  logic     prev2_r, prev2_nxt;

  logic  out_valid_r;
  byte_t out_byte_r, out_byte_nxt;
  logic  out_last_r;
  logic  emit;

  logic  accept;
  logic  is_marker;
  logic  enc_eff, comment_base, prev_eff, prev2_eff, comment_eff;
  byte_t b_in, key_b, xored, dec;
  cfg_data_t key_word;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign accept       = in_if.valid && in_if.ready;
  assign out_if.valid = out_valid_r;
  assign out_if.out_byte = out_byte_r;
  assign out_if.out_last = out_last_r;

  assign is_marker = in_if.line_start && (in_if.data_byte == MARKER);

  // a line start clears the line flags before the byte is handled
  assign enc_eff      = in_if.line_start ? 1'b0 : enc_r;
  assign comment_base = in_if.line_start ? 1'b0 : comment_r;
  assign prev_eff     = in_if.line_start ? 1'b0 : prev_r;
  assign prev2_eff    = in_if.line_start ? 1'b0 : prev2_r;
  assign comment_eff  = comment_base || (prev_eff && prev2_eff);

  assign key_word = key_words_r[{comment_eff, key_idx_r[3:2]}];
  assign key_b    = key_word[{key_idx_r[1:0], 3'b000} +: BYTE_W];
  assign b_in     = (in_if.data_byte == TAB) ? TAB_CODE : in_if.data_byte;
  assign xored    = (b_in - SPACE) ^ key_b;
  assign dec      = (xored & CHAR_MASK) + SPACE;

  always_comb begin
    enc_nxt      = enc_r;
    comment_nxt  = comment_r;
    key_idx_nxt  = key_idx_r;
    prev_nxt     = prev_r;
    prev2_nxt    = prev2_r;
    out_byte_nxt = in_if.data_byte;
    emit         = 1'b1;
    if (is_marker) begin
      enc_nxt     = 1'b1;
      comment_nxt = 1'b0;
      prev_nxt    = 1'b0;
      prev2_nxt   = 1'b0;
      key_idx_nxt = KEY_IDX_W'(in_if.line_length - LEN_W'(1));
      emit        = 1'b0;
    end else if (!enc_eff) begin
      enc_nxt     = 1'b0;
      comment_nxt = comment_base;
      prev_nxt    = prev_eff;
      prev2_nxt   = prev2_eff;
    end else begin
      comment_nxt = comment_eff;
      prev2_nxt   = prev_eff;
      prev_nxt    = (dec == SLASH);
      key_idx_nxt = key_idx_r + KEY_STEP;
      if (dec == TAB_CODE) begin
        out_byte_nxt = TAB;
      end else if (dec == SPACE_CODE) begin
        out_byte_nxt = SPACE;
      end else begin
        out_byte_nxt = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r       <= 1'b0;
      comment_r   <= 1'b0;
      key_idx_r   <= '0;
      prev_r      <= 1'b0;
      prev2_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        enc_r     <= enc_nxt;
        comment_r <= comment_nxt;
        key_idx_r <= key_idx_nxt;
        prev_r    <= prev_nxt;
        prev2_r   <= prev2_nxt;
      end
      if (accept) begin
        out_valid_r <= emit;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= in_if.line_end;
    end
  end

  // key tables: reset to the default keys; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_words_r[i]     <= MAIN_KEY_RST[i];
        key_words_r[i + 4] <= COMMENT_KEY_RST[i];
      end
    end else if (cfg_we && (cfg_index < CFG_NUM_REGS)) begin
      key_words_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  `KTLD_ASSERT_NEXT(a_marker_no_output, accept && is_marker, !out_valid_r)
  `KTLD_ASSERT_NEXT(a_byte_gives_output, accept && !is_marker, out_valid_r)
  `KTLD_ASSERT_NEXT(a_marker_key_start, accept && is_marker,
                    enc_r && (key_idx_r == $past(in_if.line_length[3:0] - 4'd1)))
  `KTLD_ASSERT_NEXT(a_pass_through, accept && !is_marker && !enc_eff,
                    out_byte_r == $past(in_if.data_byte))
  `KTLD_ASSERT_NOW(a_comment_sticky, comment_r && !in_if.line_start, comment_eff)

endmodule
